// File: hw/rtl/rtbn_pkg.sv
// rtbn_pkg: shared widths, register indexes, drive codes, payload types and the
// arctangent table for the return-to-base navigator.
// No dependencies.
`timescale 1ns / 1ps

package rtbn_pkg;

   localparam int COORD_BITS   = 16;
   localparam int CORDIC_STEPS = 16;

   // magnitudes that take part in the distance test, and their squares
   localparam int DIST_W = 16;
   localparam int SQ_W   = 2 * DIST_W;

   localparam int ANG_W     = 16;
   localparam int CSR_W     = (COORD_BITS > ANG_W) ? COORD_BITS : ANG_W;
   localparam int CSR_IDX_W = 3;

   // cordic datapath: vector components, angle accumulator, heading error
   localparam int CW      = 20;
   localparam int ZW      = 18;
   localparam int DIFF_W  = 20;

   localparam int RUN_LEN = (CORDIC_STEPS > DIST_W) ? CORDIC_STEPS : DIST_W;
   localparam int CNT_W   = $clog2(RUN_LEN);

   localparam logic signed [ZW-1:0] PI_Q13 = ZW'(25736);

   localparam logic [CSR_IDX_W-1:0] REG_BASE_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_HEAD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_HEAD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_DIST   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_TOL   = 3'd7;

   localparam logic [1:0] CMD_STOP    = 2'd0;
   localparam logic [1:0] CMD_FORWARD = 2'd1;
   localparam logic [1:0] CMD_LEFT    = 2'd2;
   localparam logic [1:0] CMD_RIGHT   = 2'd3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [ANG_W-1:0]      dir_x;
      logic signed [ANG_W-1:0]      dir_y;
   } req_type;

   typedef struct packed {
      logic [1:0] drive_cmd;
      logic       to_base;
   } rsp_type;

   // sequencer strobes shared by the cordic and distance units
   typedef struct packed {
      logic             load;
      logic             step;
      logic             finish;
      logic [CNT_W-1:0] idx;
   } ctrl_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [CNT_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (int'(i))
         0:       v = ZW'(6434);
         1:       v = ZW'(3798);
         2:       v = ZW'(2007);
         3:       v = ZW'(1019);
         4:       v = ZW'(511);
         5:       v = ZW'(256);
         6:       v = ZW'(128);
         7:       v = ZW'(64);
         8:       v = ZW'(32);
         9:       v = ZW'(16);
         10:      v = ZW'(8);
         11:      v = ZW'(4);
         12:      v = ZW'(2);
         13:      v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/rtbn_cordic.sv
// rtbn_cordic: iterative vectoring cordic, one micro-rotation per step,
// gives atan2 of the heading vector in Q2.13 radians. Uses rtbn_pkg.
`timescale 1ns / 1ps

module rtbn_cordic (
   input  logic                                  clock,
   input  rtbn_pkg::ctrl_type                    ctrl,
   input  logic signed [rtbn_pkg::ANG_W-1:0]     dir_x,
   input  logic signed [rtbn_pkg::ANG_W-1:0]     dir_y,
   output logic signed [rtbn_pkg::ZW-1:0]        heading
);
   import rtbn_pkg::*;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic                 zero_ff, zero_in;

   always_comb begin
      logic signed [CW-1:0] hx, hy, xs, ys;
      logic signed [ZW-1:0] step_ang;
      hx       = CW'(dir_x);
      hy       = CW'(dir_y);
      xs       = x_ff >>> ctrl.idx;
      ys       = y_ff >>> ctrl.idx;
      step_ang = atan_entry(ctrl.idx);
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      zero_in  = zero_ff;
      if (ctrl.load) begin
         zero_in = (dir_x == '0) && (dir_y == '0);
         // left half plane: rotate by pi first
         if (hx < 0) begin
            x_in = -hx;
            y_in = -hy;
            z_in = (hy >= 0) ? PI_Q13 : -PI_Q13;
         end else begin
            x_in = hx;
            y_in = hy;
            z_in = '0;
         end
      end else if (ctrl.step && ({1'b0, ctrl.idx} < (CNT_W+1)'(CORDIC_STEPS))) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   assign heading = zero_ff ? '0 : z_ff;

endmodule

// File: hw/rtl/rtbn_dist.sv
// rtbn_dist: bit-serial squares of two coordinate distances and of the reach
// threshold, one multiplier bit per step, then the squared compare. Uses rtbn_pkg.
`timescale 1ns / 1ps

module rtbn_dist (
   input  logic                                   clock,
   input  rtbn_pkg::ctrl_type                     ctrl,
   input  logic signed [rtbn_pkg::COORD_BITS-1:0] ax,
   input  logic signed [rtbn_pkg::COORD_BITS-1:0] ay,
   input  logic signed [rtbn_pkg::COORD_BITS-1:0] bx,
   input  logic signed [rtbn_pkg::COORD_BITS-1:0] by,
   input  logic [rtbn_pkg::DIST_W-1:0]            near_dist,
   output logic                                   is_near
);
   import rtbn_pkg::*;

   logic              far_ff, far_in;
   logic [DIST_W-1:0] mx_ff, mx_in, my_ff, my_in, mn_ff, mn_in;
   logic [SQ_W-1:0]   cx_ff, cx_in, cy_ff, cy_in, cn_ff, cn_in;
   logic [SQ_W-1:0]   accx_ff, accx_in, accy_ff, accy_in, accn_ff, accn_in;
   logic              near_ff, near_in;

   always_comb begin
      logic signed [COORD_BITS:0] dxs, dys;
      logic [COORD_BITS:0]        magx, magy;
      logic [47:0]                widex, widey;
      logic [SQ_W:0]              d2;
      dxs     = (COORD_BITS+1)'(ax) - (COORD_BITS+1)'(bx);
      dys     = (COORD_BITS+1)'(ay) - (COORD_BITS+1)'(by);
      magx    = dxs[COORD_BITS] ? (COORD_BITS+1)'(-dxs) : (COORD_BITS+1)'(dxs);
      magy    = dys[COORD_BITS] ? (COORD_BITS+1)'(-dys) : (COORD_BITS+1)'(dys);
      widex   = 48'(magx);
      widey   = 48'(magy);
      d2      = {1'b0, accx_ff} + {1'b0, accy_ff};
      far_in  = far_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      mn_in   = mn_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cn_in   = cn_ff;
      accx_in = accx_ff;
      accy_in = accy_ff;
      accn_in = accn_ff;
      near_in = near_ff;
      if (ctrl.load) begin
         // a difference of 65536 or more never counts as near
         far_in  = (|widex[47:DIST_W]) || (|widey[47:DIST_W]);
         mx_in   = widex[DIST_W-1:0];
         my_in   = widey[DIST_W-1:0];
         mn_in   = near_dist;
         cx_in   = SQ_W'(widex[DIST_W-1:0]);
         cy_in   = SQ_W'(widey[DIST_W-1:0]);
         cn_in   = SQ_W'(near_dist);
         accx_in = '0;
         accy_in = '0;
         accn_in = '0;
      end else if (ctrl.step) begin
         if (mx_ff[0]) accx_in = accx_ff + cx_ff;
         if (my_ff[0]) accy_in = accy_ff + cy_ff;
         if (mn_ff[0]) accn_in = accn_ff + cn_ff;
         mx_in = mx_ff >> 1;
         my_in = my_ff >> 1;
         mn_in = mn_ff >> 1;
         cx_in = cx_ff << 1;
         cy_in = cy_ff << 1;
         cn_in = cn_ff << 1;
      end else if (ctrl.finish) begin
         near_in = !far_ff && (d2 < {1'b0, accn_ff});
      end
   end

   always_ff @(posedge clock) begin
      far_ff  <= far_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mn_ff   <= mn_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cn_ff   <= cn_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      accn_ff <= accn_in;
      near_ff <= near_in;
   end

   assign is_near = near_ff;

endmodule

// File: hw/rtl/return_to_base_navigator.sv
// return_to_base_navigator: one pose item in, one drive command out.
// From accept to result valid an item passes ST_STEP, ST_FINISH and ST_DECIDE; the length
// of ST_STEP is set by the step count of the cordic and the serial squarers.
// A new item is taken only in ST_IDLE, once the last one has left ST_DECIDE; a waiting
// result holds the next item in its decide cycle, which stalls further input.
// Reset (synchronous): stop pending, buffer stage, last position 0, registers to
// their reset values, no result held.
`timescale 1ns / 1ps

module return_to_base_navigator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rtbn_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rtbn_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rtbn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rtbn_pkg::CSR_W-1:0]            csr_data
);
   import rtbn_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_STEP   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic             stage_ff, stage_in;
   logic signed [COORD_BITS-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;

   logic signed [COORD_BITS-1:0] base_x_ff, base_y_ff, buffer_x_ff, buffer_y_ff;
   logic signed [ANG_W-1:0]      base_head_ff, buffer_head_ff;
   logic [DIST_W-1:0]            near_dist_ff;
   logic [ANG_W-1:0]             angle_tol_ff;

   logic signed [ANG_W-1:0]  th_ff, th_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                         accept, out_free;
   ctrl_type                     ctrl;
   logic signed [COORD_BITS-1:0] ref_x, ref_y;
   logic signed [ZW-1:0]         heading;
   logic                         is_near;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign ctrl = '{load:   accept,
                   step:   (state_ff == ST_STEP),
                   finish: (state_ff == ST_FINISH),
                   idx:    cnt_ff};

   // while a stop is pending the distance is to the previous position
   assign ref_x = pend_ff ? last_x_ff : (stage_ff ? base_x_ff : buffer_x_ff);
   assign ref_y = pend_ff ? last_y_ff : (stage_ff ? base_y_ff : buffer_y_ff);

   rtbn_cordic u_cordic (
      .clock   (clock),
      .ctrl    (ctrl),
      .dir_x   (req_data.dir_x),
      .dir_y   (req_data.dir_y),
      .heading (heading)
   );

   rtbn_dist u_dist (
      .clock     (clock),
      .ctrl      (ctrl),
      .ax        (req_data.pos_x),
      .ay        (req_data.pos_y),
      .bx        (ref_x),
      .by        (ref_y),
      .near_dist (near_dist_ff),
      .is_near   (is_near)
   );

   always_comb begin
      logic [DIFF_W-1:0] err_mag;
      err_mag      = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : DIFF_W'(diff_ff);
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      stage_in     = stage_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      th_in        = th_ff;
      diff_in      = diff_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_STEP;
               cnt_in    = '0;
               th_in     = stage_ff ? base_head_ff : buffer_head_ff;
               last_x_in = req_data.pos_x;
               last_y_in = req_data.pos_y;
            end
         end
         ST_STEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RUN_LEN - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            diff_in  = DIFF_W'(th_ff) - DIFF_W'(heading);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in.drive_cmd = CMD_STOP;
               if (pend_ff) begin
                  if (is_near) pend_in = 1'b0;
               end else if (is_near) begin
                  pend_in  = 1'b1;
                  stage_in = 1'b1;
               end else if (err_mag < DIFF_W'(angle_tol_ff)) begin
                  rsp_data_in.drive_cmd = CMD_FORWARD;
               end else if (diff_ff > 0) begin
                  rsp_data_in.drive_cmd = CMD_LEFT;
               end else begin
                  rsp_data_in.drive_cmd = CMD_RIGHT;
               end
               rsp_data_in.to_base = stage_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b1;
         stage_ff     <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         stage_ff     <= stage_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      th_ff       <= th_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff      <= '0;
         base_y_ff      <= '0;
         base_head_ff   <= '0;
         buffer_x_ff    <= '0;
         buffer_y_ff    <= '0;
         buffer_head_ff <= '0;
         near_dist_ff   <= DIST_W'(64);
         angle_tol_ff   <= ANG_W'(819);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BASE_X:      base_x_ff      <= csr_data[COORD_BITS-1:0];
            REG_BASE_Y:      base_y_ff      <= csr_data[COORD_BITS-1:0];
            REG_BASE_HEAD:   base_head_ff   <= csr_data[ANG_W-1:0];
            REG_BUFFER_X:    buffer_x_ff    <= csr_data[COORD_BITS-1:0];
            REG_BUFFER_Y:    buffer_y_ff    <= csr_data[COORD_BITS-1:0];
            REG_BUFFER_HEAD: buffer_head_ff <= csr_data[ANG_W-1:0];
            REG_NEAR_DIST:   near_dist_ff   <= csr_data[DIST_W-1:0];
            REG_ANGLE_TOL:   angle_tol_ff   <= csr_data[ANG_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_STEP) && (cnt_ff == '0))
      else $error("accepted item did not start the step sequence");

   a_result_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DECIDE))
      else $error("result appeared outside the decide cycle");

   a_decide_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("decide cycle with free output did not deliver");

   a_finish_after_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> ($past(state_ff) == ST_STEP))
      else $error("finish reached without the step sequence");

endmodule

// File: bench/rtbn_checker.sv
// rtbn_checker: watches the pose, command and register channels of the
// return-to-base navigator, predicts every drive command and compares it.
// Depends on rtbn_pkg for the payload types, register indexes and drive codes.
`timescale 1ns / 1ps

module rtbn_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  rtbn_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  rtbn_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [rtbn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtbn_pkg::CSR_W-1:0]     csr_data,
   output int                             failures,
   output int                             outstanding,
   output int                             checked
);
   import rtbn_pkg::*;

   logic signed [COORD_BITS-1:0] base_x, base_y, buffer_x, buffer_y;
   logic signed [COORD_BITS-1:0] last_x, last_y;
   logic signed [ANG_W-1:0]      base_head, buffer_head;
   logic [15:0]                  near_dist, angle_tol;
   logic                         stop_pending, base_stage;

   rsp_type expected_cmds [$];

   longint atan_q13 [24] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4,
                             2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

   initial begin
      failures    = 0;
      outstanding = 0;
      checked     = 0;
   end

   // squared distance test, coordinate gaps of 65536 or more never count as near
   function automatic bit within_reach(longint ax, longint ay, longint bx, longint by);
      longint dx, dy, d2, n2;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      if (dx >= 65536 || dy >= 65536) return 1'b0;
      d2 = dx * dx + dy * dy;
      n2 = longint'(near_dist) * longint'(near_dist);
      return d2 < n2;
   endfunction

   // vectoring cordic, result in Q2.13 radians
   function automatic longint vector_angle(longint x, longint y);
      longint z, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(PI_Q13) : -longint'(PI_Q13);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += atan_q13[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= atan_q13[i];
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   function automatic rsp_type advance_pose(req_type p);
      rsp_type    r;
      longint     tx, ty, th, err;
      logic [1:0] cmd;
      cmd = CMD_STOP;
      if (stop_pending) begin
         if (within_reach(longint'(p.pos_x), longint'(p.pos_y),
                          longint'(last_x), longint'(last_y)))
            stop_pending = 1'b0;
      end else begin
         tx = base_stage ? longint'(base_x) : longint'(buffer_x);
         ty = base_stage ? longint'(base_y) : longint'(buffer_y);
         th = base_stage ? longint'(base_head) : longint'(buffer_head);
         if (within_reach(longint'(p.pos_x), longint'(p.pos_y), tx, ty)) begin
            stop_pending = 1'b1;
            base_stage   = 1'b1;
         end else begin
            // heading error is left unwrapped
            err = th - vector_angle(longint'(p.dir_x), longint'(p.dir_y));
            if (((err < 0) ? -err : err) < longint'(angle_tol)) cmd = CMD_FORWARD;
            else if (err > 0) cmd = CMD_LEFT;
            else cmd = CMD_RIGHT;
         end
      end
      last_x = p.pos_x;
      last_y = p.pos_y;
      r.drive_cmd = cmd;
      r.to_base   = base_stage;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         base_x       = '0;
         base_y       = '0;
         base_head    = '0;
         buffer_x     = '0;
         buffer_y     = '0;
         buffer_head  = '0;
         near_dist    = 16'd64;
         angle_tol    = 16'd819;
         stop_pending = 1'b1;
         base_stage   = 1'b0;
         last_x       = '0;
         last_y       = '0;
         expected_cmds.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BASE_X:      base_x      = csr_data[COORD_BITS-1:0];
               REG_BASE_Y:      base_y      = csr_data[COORD_BITS-1:0];
               REG_BASE_HEAD:   base_head   = csr_data[ANG_W-1:0];
               REG_BUFFER_X:    buffer_x    = csr_data[COORD_BITS-1:0];
               REG_BUFFER_Y:    buffer_y    = csr_data[COORD_BITS-1:0];
               REG_BUFFER_HEAD: buffer_head = csr_data[ANG_W-1:0];
               REG_NEAR_DIST:   near_dist   = csr_data[15:0];
               REG_ANGLE_TOL:   angle_tol   = csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               $error("drive command item arrived with no pose item waiting");
               failures++;
            end else begin
               want = expected_cmds.pop_front();
               checked++;
               if (rsp_data.drive_cmd !== want.drive_cmd) begin
                  $error("drive_cmd expected %0d actual %0d", want.drive_cmd,
                         rsp_data.drive_cmd);
                  failures++;
               end
               if (rsp_data.to_base !== want.to_base) begin
                  $error("to_base expected %0d actual %0d", want.to_base, rsp_data.to_base);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) expected_cmds.push_back(advance_pose(req_data));
      end
      outstanding = expected_cmds.size();
   end

endmodule

// File: bench/tb.sv
// tb: drives pose items and register writes into the return-to-base navigator
// with random idling and a long result hold-off; rtbn_checker does the checking.
// Depends on rtbn_pkg, return_to_base_navigator and rtbn_checker.
`timescale 1ns / 1ps

module tb;
   import rtbn_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 6;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid, req_stall;
   req_type              req_data;
   logic                 rsp_valid, rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_data;

   int failures, outstanding, checked;
   int cycles   = 0;
   int sent     = 0;
   int settings = 0;
   int tx_max   = 14;
   int rx_max   = 14;
   bit hold_request = 1'b0;
   int cfg [8] = '{0, 0, 0, 0, 0, 0, 64, 819};

   always #4 clock = ~clock;

   return_to_base_navigator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rtbn_checker nav_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int edge_value();
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return 32767;
         2:       return -32768;
         3:       return -1;
         default: return 1;
      endcase
   endfunction

   function automatic req_type pose(int x, int y, int dx, int dy);
      req_type p;
      p.pos_x = COORD_BITS'(x);
      p.pos_y = COORD_BITS'(y);
      p.dir_x = ANG_W'(dx);
      p.dir_y = ANG_W'(dy);
      return p;
   endfunction

   // entered and left just after a falling edge; valid stays high for a zero gap
   task automatic send_pose(req_type p);
      int gap;
      gap = $urandom_range(0, tx_max);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = p;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = CSR_W'(val);
      cfg[idx]  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   // result side: random stall before each item, one long hold-off on request
   initial begin
      int w;
      rsp_stall = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            w = $urandom_range(0, rx_max);
            if (w > 0) begin
               rsp_stall = 1'b1;
               repeat (w) @(negedge clock);
            end
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int  count, r, tsel, reach, px, py, dx, dy, th, spread, ang, mag;
      int  last_px, last_py;
      int  nd, tol;
      real a;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      last_px   = 0;
      last_py   = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed poses with the registers at their reset values
      send_pose(pose(0, 0, 0, 0));               // close to last position clears stop
      send_pose(pose(-32768, -32768, 32767, 0));
      send_pose(pose(32767, 32767, -32768, 0));  // heading of pi
      send_pose(pose(-32768, 32767, -32768, -1));
      send_pose(pose(32767, -32768, 0, 32767));
      send_pose(pose(1000, -1000, 0, -32768));
      send_pose(pose(500, 500, 32767, 32767));
      send_pose(pose(30, -40, 1, 1));            // buffer reached
      send_pose(pose(-32768, 32767, 5, 5));
      send_pose(pose(32767, -32768, 0, 0));      // full-range gap never near
      send_pose(pose(32767, -32760, 0, 0));
      send_pose(pose(100, 100, 0, 0));           // zero vector heads at 0
      send_pose(pose(63, 0, 1, 0));              // base reached, stage stays
      send_pose(pose(64, 0, 7, 7));
      send_pose(pose(64, 0, 32767, -32768));     // exactly at the distance is not near
      send_pose(pose(0, -64, -1, 0));
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin nd = $urandom_range(32, 3000); tol = $urandom_range(100, 4000); end
            1: begin nd = 65535; tol = 51472; end
            2: begin nd = 0; tol = 0; end
            4: begin nd = $urandom_range(1, 16); tol = $urandom_range(0, 51472); end
            default: begin nd = $urandom_range(1, 2000); tol = $urandom_range(200, 3000); end
         endcase
         case (ph)
            1: begin
               write_reg(REG_BASE_X, 32767);
               write_reg(REG_BASE_Y, 32767);
               write_reg(REG_BASE_HEAD, 25736);
               write_reg(REG_BUFFER_X, -32768);
               write_reg(REG_BUFFER_Y, -32768);
               write_reg(REG_BUFFER_HEAD, -25736);
            end
            2: begin
               write_reg(REG_BASE_X, -32768);
               write_reg(REG_BASE_Y, -32768);
               write_reg(REG_BASE_HEAD, -25736);
               write_reg(REG_BUFFER_X, 32767);
               write_reg(REG_BUFFER_Y, 32767);
               write_reg(REG_BUFFER_HEAD, 25736);
            end
            default: begin
               // first phase keeps targets moderate, later ones use the full range
               reach = (ph == 0) ? 4000 : 32768;
               write_reg(REG_BASE_X, clamp16(int'($urandom_range(0, 2 * reach)) - reach));
               write_reg(REG_BASE_Y, clamp16(int'($urandom_range(0, 2 * reach)) - reach));
               write_reg(REG_BASE_HEAD, int'($urandom_range(0, 51472)) - 25736);
               write_reg(REG_BUFFER_X, clamp16(int'($urandom_range(0, 2 * reach)) - reach));
               write_reg(REG_BUFFER_Y, clamp16(int'($urandom_range(0, 2 * reach)) - reach));
               write_reg(REG_BUFFER_HEAD, int'($urandom_range(0, 51472)) - 25736);
            end
         endcase
         write_reg(REG_NEAR_DIST, nd);
         write_reg(REG_ANGLE_TOL, tol);
         csr_valid = 1'b0;
         settings++;

         case (ph)
            1:       begin count = 150; tx_max = 0;  rx_max = 0;  end
            2:       begin count = 40;  tx_max = 14; rx_max = 14; end
            3:       begin count = 220; tx_max = 0;  rx_max = 14; hold_request = 1'b1; end
            4:       begin count = 220; tx_max = 14; rx_max = 14; end
            5:       begin count = 200; tx_max = 0;  rx_max = 14; end
            default: begin count = 200; tx_max = 14; rx_max = 14; end
         endcase

         for (int k = 0; k < count; k++) begin
            tsel  = $urandom_range(0, 1);
            reach = cfg[REG_NEAR_DIST] / 3;
            if (reach > 3000) reach = 3000;
            r = $urandom_range(0, 99);
            if (r < 40) begin
               // small step from the last position, lets a pending stop clear
               px = clamp16(last_px + int'($urandom_range(0, 2 * reach)) - reach);
               py = clamp16(last_py + int'($urandom_range(0, 2 * reach)) - reach);
            end else if (r < 55) begin
               px = clamp16((tsel ? cfg[REG_BASE_X] : cfg[REG_BUFFER_X])
                            + int'($urandom_range(0, 2 * reach)) - reach);
               py = clamp16((tsel ? cfg[REG_BASE_Y] : cfg[REG_BUFFER_Y])
                            + int'($urandom_range(0, 2 * reach)) - reach);
            end else begin
               px = int'($urandom_range(0, 65535)) - 32768;
               py = int'($urandom_range(0, 65535)) - 32768;
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
               // heading close to the target heading, straddling the tolerance
               th     = tsel ? cfg[REG_BASE_HEAD] : cfg[REG_BUFFER_HEAD];
               spread = ((cfg[REG_ANGLE_TOL] > 8000) ? 8000 : cfg[REG_ANGLE_TOL]) + 300;
               ang    = th + int'($urandom_range(0, 2 * spread)) - spread;
               mag    = $urandom_range(64, 32767);
               a      = real'(ang) / 8192.0;
               dx     = $rtoi(real'(mag) * $cos(a));
               dy     = $rtoi(real'(mag) * $sin(a));
            end else if (r < 45) begin
               dx = edge_value();
               dy = edge_value();
            end else begin
               dx = int'($urandom_range(0, 65535)) - 32768;
               dy = int'($urandom_range(0, 65535)) - 32768;
            end
            send_pose(pose(px, py, dx, dy));
            last_px = px;
            last_py = py;
         end
         wait_drained();
      end

      $display("tb: %0d pose items over %0d register settings, %0d commands compared",
               sent, settings, checked);
      $display("tb: extremes of targets, reach distance and tolerance, plus a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (failures == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
